[hdl/oaht_pkg.sv]
// ----------------------------------------------------------------------------
// oaht_pkg: shared types and constants for the open address hash table
// Command and status codes, FSM states, and the probe unit interface structs.
// ----------------------------------------------------------------------------
package oaht_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	localparam int HASH_W    = 32;
	localparam int CNT_W     = 11;
	localparam int SLOT_W    = 10;    // index width of the largest table (1024 slots)
	localparam int CODE_W    = 4;
	localparam int LG_W      = 4;
	localparam logic [CODE_W-1:0] CODE_MAX = 4'd11;
	localparam int LG_MAX    = 10;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STS_DONE      = 3'd0,
		STS_PRESENT   = 3'd1,
		STS_NOT_FOUND = 3'd2,
		STS_FULL      = 3'd3,
		STS_NO_SLOT   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'd0,
		ST_IDLE  = 2'd1,
		ST_PROBE = 2'd2
	} state_t;

	// probe unit control and status
	typedef struct packed {
		logic load;   // start a new probe sequence
		logic adv;    // step to the next slot
	} probe_ctl_t;

	typedef struct packed {
		logic blocked;  // slot holds a different key
		logic last;     // no step left
	} probe_sts_t;

	// log2 of the slot count for a size code, capped at lg_cap; code 0 is handled apart
	function automatic logic [LG_W-1:0] lg_of_code(input logic [CODE_W-1:0] code,
			input logic [LG_W-1:0] lg_cap);
		logic [CODE_W-1:0] c;
		logic [LG_W-1:0]   l;
		c = (code > CODE_MAX) ? CODE_MAX : code;
		l = LG_W'(c - 4'd1);
		return (l > lg_cap) ? lg_cap : l;
	endfunction

endpackage

[hdl/oaht_ram.sv]
// ----------------------------------------------------------------------------
// oaht_ram: generic single port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module oaht_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[hdl/oaht_probe.sv]
// ----------------------------------------------------------------------------
// oaht_probe: probe sequence unit
// Holds slot index and step; one add-and-mask per step, key compare on read data.
// ----------------------------------------------------------------------------
module oaht_probe (
	input  logic                         clk,
	input  oaht_pkg::probe_ctl_t         ctl,
	input  logic [oaht_pkg::HASH_W-1:0]  hash,
	input  logic [oaht_pkg::SLOT_W-1:0]  mask,
	input  logic [oaht_pkg::KEY_W-1:0]   key_req,
	input  logic [oaht_pkg::KEY_W-1:0]   rd_key,
	output logic [oaht_pkg::SLOT_W-1:0]  addr_nxt,
	output logic [oaht_pkg::SLOT_W-1:0]  idx,
	output oaht_pkg::probe_sts_t         sts
);

	logic [oaht_pkg::SLOT_W-1:0] idx_q;
	logic [oaht_pkg::SLOT_W-1:0] step_q;

	always_comb begin
		priority if (ctl.load) begin
			addr_nxt = hash[oaht_pkg::SLOT_W-1:0] & mask;
		end else if (ctl.adv) begin
			addr_nxt = (idx_q + step_q) & mask;
		end else begin
			addr_nxt = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			idx_q  <= addr_nxt;
			step_q <= mask;
		end else if (ctl.adv) begin
			idx_q  <= addr_nxt;
			step_q <= step_q - 1'b1;
		end
	end

	assign idx         = idx_q;
	assign sts.blocked = (rd_key != '0) && (rd_key != key_req);
	assign sts.last    = (step_q == '0);

endmodule

[hdl/open_address_hash_table.sv]
// ----------------------------------------------------------------------------
// open_address_hash_table: key/value table with open addressing
// Insert, lookup, update and remove over one key/value RAM, probed one slot
// per cycle with steps of size-1, size-2, ... 1 from key_hash AND (size-1).
// ----------------------------------------------------------------------------
//
// Channel  | Handshake         | Payload
// ---------+-------------------+---------------------------------------------
// command  | start, busy       | cmd, key, key_hash, value
// result   | done (1 cycle)    | status, value_out, entry_count_out,
//          |                   | full_flag, sparse_flag
// config   | cfg_we            | cfg_wdata (size code)
//
// Flow: an item is taken when start is high and busy low. A refused item
// (zero key, zero value on insert or update, full on insert, zero-size
// table) shows its result in the cycle after it is taken. A probed item
// reads its slots in turn: each RAM read is registered, and the shared
// probe unit steps once per cycle until a free or matching slot or its last step.
// Reset and every size write start a clearing pass over all DEPTH words of
// the RAM; busy is high during it.
// The result receiver cannot stall; done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module open_address_hash_table #(
	parameter int DEPTH = oaht_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    cmd,
	input  logic [oaht_pkg::KEY_W-1:0]    key,
	input  logic [oaht_pkg::HASH_W-1:0]   key_hash,
	input  logic [oaht_pkg::VAL_W-1:0]    value,
	// result
	output logic                          done,
	output logic [2:0]                    status,
	output logic [oaht_pkg::VAL_W-1:0]    value_out,
	output logic [oaht_pkg::CNT_W-1:0]    entry_count_out,
	output logic                          full_flag,
	output logic                          sparse_flag,
	// config
	input  logic                          cfg_we,
	input  logic [oaht_pkg::CODE_W-1:0]   cfg_wdata
);

	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LG_DEP = $clog2(DEPTH + 1) - 1;   // floor(log2(DEPTH))
	localparam int LG_CAP = (LG_DEP > oaht_pkg::LG_MAX) ? oaht_pkg::LG_MAX : LG_DEP;
	localparam int RW     = oaht_pkg::KEY_W + oaht_pkg::VAL_W;

	// ------------------------------------------------------------------
	// Table size
	// ------------------------------------------------------------------
	logic                         zero_q;      // zero-size table
	logic [oaht_pkg::LG_W-1:0]    lg_q;        // log2 of slot count
	logic [oaht_pkg::CNT_W-1:0]   size_v;
	logic [oaht_pkg::SLOT_W-1:0]  mask;
	logic [oaht_pkg::CNT_W-1:0]   full_lim;
	logic [oaht_pkg::CNT_W:0]     sparse_sum;
	logic [oaht_pkg::CNT_W-1:0]   sparse_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= 1'b0;
			lg_q   <= oaht_pkg::lg_of_code(oaht_pkg::CODE_MAX, oaht_pkg::LG_W'(LG_CAP));
		end else if (cfg_we) begin
			zero_q <= (cfg_wdata == '0);
			lg_q   <= oaht_pkg::lg_of_code(cfg_wdata, oaht_pkg::LG_W'(LG_CAP));
		end
	end

	assign size_v     = zero_q ? '0 : (oaht_pkg::CNT_W'(1) << lg_q);
	assign mask       = oaht_pkg::SLOT_W'(size_v - 1'b1);
	// limit is size itself for tiny tables, else 3/4 of size
	assign full_lim   = (size_v <= oaht_pkg::CNT_W'(4)) ? size_v : (size_v - (size_v >> 2));
	assign sparse_sum = (oaht_pkg::CNT_W+1)'(size_v) + (oaht_pkg::CNT_W+1)'(size_v >> 1)
		+ (oaht_pkg::CNT_W+1)'(2);
	assign sparse_lim = oaht_pkg::CNT_W'(sparse_sum >> 2);

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	oaht_pkg::state_t            state_q, state_d;
	logic [AW-1:0]               clr_q;
	logic                        clr_last;
	logic [oaht_pkg::CNT_W-1:0]  count_q;
	oaht_pkg::cmd_t              cmd_q;
	logic [oaht_pkg::KEY_W-1:0]  key_q;
	logic [oaht_pkg::VAL_W-1:0]  val_q;

	logic                        accept;
	logic                        reject;
	oaht_pkg::status_t           rej_status;

	// RAM and probe unit
	logic                        ram_we;
	logic [AW-1:0]               ram_addr;
	logic [RW-1:0]               ram_wdata;
	logic [RW-1:0]               ram_rdata;
	logic [oaht_pkg::KEY_W-1:0]  rd_key;
	logic [oaht_pkg::VAL_W-1:0]  rd_val;
	oaht_pkg::probe_ctl_t        pctl;
	oaht_pkg::probe_sts_t        psts;
	logic [oaht_pkg::SLOT_W-1:0] p_addr;
	logic [oaht_pkg::SLOT_W-1:0] p_idx;

	// result
	logic                        res_v;
	oaht_pkg::status_t           res_status;
	logic [oaht_pkg::VAL_W-1:0]  res_vout;
	logic                        res_sparse;
	logic [oaht_pkg::CNT_W-1:0]  count_d;
	logic [oaht_pkg::CNT_W-1:0]  count_dec;

	logic                        done_q;
	oaht_pkg::status_t           status_q;
	logic [oaht_pkg::VAL_W-1:0]  vout_q;
	logic                        sparse_q;

	assign busy     = (state_q != oaht_pkg::ST_IDLE);
	assign accept   = start && (state_q == oaht_pkg::ST_IDLE);
	assign clr_last = (clr_q == AW'(DEPTH - 1));
	assign rd_key   = ram_rdata[RW-1 -: oaht_pkg::KEY_W];
	assign rd_val   = ram_rdata[oaht_pkg::VAL_W-1:0];
	assign count_dec = (count_q != '0) ? (count_q - 1'b1) : count_q;

	// items answered without probing
	always_comb begin
		reject     = 1'b1;
		rej_status = oaht_pkg::STS_NOT_FOUND;
		priority if (key == '0) begin
			rej_status = oaht_pkg::STS_NOT_FOUND;
		end else if ((cmd == oaht_pkg::CMD_INSERT || cmd == oaht_pkg::CMD_UPDATE)
				&& value == '0) begin
			rej_status = oaht_pkg::STS_NO_SLOT;
		end else if (cmd == oaht_pkg::CMD_INSERT && count_q >= full_lim) begin
			rej_status = oaht_pkg::STS_FULL;
		end else if (zero_q) begin
			rej_status = oaht_pkg::STS_NOT_FOUND;
		end else begin
			reject = 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oaht_pkg::ST_CLEAR: begin
				if (clr_last) state_d = oaht_pkg::ST_IDLE;
			end
			oaht_pkg::ST_IDLE: begin
				if (accept && !reject) state_d = oaht_pkg::ST_PROBE;
			end
			oaht_pkg::ST_PROBE: begin
				if (!(psts.blocked && !psts.last)) state_d = oaht_pkg::ST_IDLE;
			end
			default: state_d = oaht_pkg::ST_CLEAR;
		endcase
		if (cfg_we) state_d = oaht_pkg::ST_CLEAR;   // size write empties the table
	end

	// outputs of the sequencer
	always_comb begin
		ram_we     = 1'b0;
		ram_addr   = AW'(p_addr);
		ram_wdata  = '0;
		pctl.load  = 1'b0;
		pctl.adv   = 1'b0;
		res_v      = 1'b0;
		res_status = oaht_pkg::STS_NOT_FOUND;
		res_vout   = '0;
		res_sparse = 1'b0;
		count_d    = count_q;
		unique case (state_q)
			oaht_pkg::ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			oaht_pkg::ST_IDLE: begin
				if (accept) begin
					if (reject) begin
						res_v      = 1'b1;
						res_status = rej_status;
					end else begin
						pctl.load = 1'b1;   // first slot read issued now
					end
				end
			end
			oaht_pkg::ST_PROBE: begin
				if (psts.blocked && !psts.last) begin
					pctl.adv = 1'b1;
				end else begin
					res_v    = 1'b1;
					ram_addr = AW'(p_idx);
					if (cmd_q == oaht_pkg::CMD_INSERT) begin
						priority if (psts.blocked) begin
							res_status = oaht_pkg::STS_NO_SLOT;
						end else if (rd_val != '0) begin
							res_status = oaht_pkg::STS_PRESENT;
							res_vout   = rd_val;
						end else begin
							// empty slot or own tombstone
							res_status = oaht_pkg::STS_DONE;
							ram_we     = 1'b1;
							ram_wdata  = {key_q, val_q};
							count_d    = count_q + 1'b1;
						end
					end else if (!psts.blocked && rd_key == key_q && rd_val != '0) begin
						res_status = oaht_pkg::STS_DONE;
						res_vout   = rd_val;
						if (cmd_q == oaht_pkg::CMD_UPDATE) begin
							ram_we    = 1'b1;
							ram_wdata = {key_q, val_q};
						end else if (cmd_q == oaht_pkg::CMD_REMOVE) begin
							// key stays as a tombstone
							ram_we     = 1'b1;
							ram_wdata  = {key_q, oaht_pkg::VAL_W'(0)};
							count_d    = count_dec;
							res_sparse = (count_dec <= sparse_lim);
						end
					end else begin
						res_status = oaht_pkg::STS_NOT_FOUND;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oaht_pkg::ST_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_v && !cfg_we;
			if (cfg_we) begin
				clr_q   <= '0;
				count_q <= '0;
			end else begin
				if (state_q == oaht_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
				count_q <= count_d;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= oaht_pkg::cmd_t'(cmd);
			key_q <= key;
			val_q <= value;
		end
		if (res_v) begin
			status_q <= res_status;
			vout_q   <= res_vout;
			sparse_q <= res_sparse;
		end
	end

	oaht_probe u_probe (
		.clk      (clk),
		.ctl      (pctl),
		.hash     (key_hash),
		.mask     (mask),
		.key_req  (key_q),
		.rd_key   (rd_key),
		.addr_nxt (p_addr),
		.idx      (p_idx),
		.sts      (psts)
	);

	oaht_ram #(
		.WIDTH (RW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign done            = done_q;
	assign status          = status_q;
	assign value_out       = vout_q;
	assign entry_count_out = count_q;
	assign full_flag       = (count_q >= full_lim);
	assign sparse_flag     = sparse_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	// a result only follows an accept or the end of a probe
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(accept || state_q == oaht_pkg::ST_PROBE))
		else $error("result without a source item");

	// live entries never exceed the slot count
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= size_v)
		else $error("entry count above table size");

	// sparse only comes with a completed operation
	a_sparse_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && sparse_q) |-> (status_q == oaht_pkg::STS_DONE))
		else $error("sparse flag on a failed item");

	// a full refusal is consistent with the full flag
	a_full_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == oaht_pkg::STS_FULL) |-> full_flag)
		else $error("full refusal while not full");

endmodule

[tb/open_address_hash_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_address_hash_table_tb: self-checking bench for the hash table
// Drives insert/lookup/update/remove items over start/busy, keeps its own copy
// of the key/value slots and compares every done strobe against it. A short
// directed table comes first, then random phases over many table sizes.
// ----------------------------------------------------------------------------
module open_address_hash_table_tb;
	import oaht_pkg::*;

	localparam int SLOTS = DEPTH_DEF;

	// one predicted reply of the table
	typedef struct {
		status_t     st;
		logic [31:0] vout;
		logic [10:0] cnt;
		logic        full;
		logic        sparse;
	} reply_t;

	// one row of the directed table: a size write or an item
	typedef struct {
		bit          is_size;
		logic [3:0]  code;
		cmd_t        op;
		logic [31:0] k;
		logic [31:0] h;
		logic [31:0] v;
		bit          typed;    // expected reply written in the row
		reply_t      want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [31:0] key;
	logic [31:0] key_hash;
	logic [31:0] value;
	logic        done;
	logic [2:0]  status;
	logic [31:0] value_out;
	logic [10:0] entry_count_out;
	logic        full_flag;
	logic        sparse_flag;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;

	// shadow of the table
	bit [31:0]   slot_key [SLOTS];
	bit [31:0]   slot_val [SLOTS];
	int unsigned live_count;
	int unsigned tbl_slots;

	reply_t      table_replies[$];   // replies still owed by the block, oldest first
	row_t        directed_rows[$];
	int          mismatches;

	open_address_hash_table dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.key            (key),
		.key_hash       (key_hash),
		.value          (value),
		.done           (done),
		.status         (status),
		.value_out      (value_out),
		.entry_count_out(entry_count_out),
		.full_flag      (full_flag),
		.sparse_flag    (sparse_flag),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop far beyond the slowest legal run
	initial begin
		#100_000_000;
		$display("FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	// codes above 11 saturate, 0 means no slots at all
	function automatic int unsigned slots_for(input logic [3:0] code);
		int unsigned s;
		if (code == 4'd0)
			return 0;
		s = 1 << ((code > 4'd11 ? 4'd11 : code) - 1);
		while (s > SLOTS)
			s = s >> 1;
		return s;
	endfunction

	function automatic int unsigned fill_limit();
		return (tbl_slots <= 4) ? tbl_slots : tbl_slots - (tbl_slots >> 2);
	endfunction

	// walk hash, +size-1, +size-2 ... until an empty or matching key or no step is left
	function automatic bit probe_slot(input logic [31:0] k, input logic [31:0] h,
			output int unsigned at);
		int unsigned mask;
		int unsigned i;
		int unsigned s;
		bit          blocked;
		at = 0;
		if (tbl_slots == 0)
			return 1'b0;
		mask = tbl_slots - 1;
		i = h & mask;
		s = mask;
		while (1) begin
			blocked = (slot_key[i] != 0) && (slot_key[i] != k);
			if (!blocked || s == 0)
				break;
			i = (i + s) & mask;
			s--;
		end
		at = i;
		return !blocked;
	endfunction

	// apply one item to the shadow table and return what the block must report
	function automatic reply_t table_apply(input cmd_t op, input logic [31:0] k,
			input logic [31:0] h, input logic [31:0] v);
		reply_t      r;
		int unsigned at;
		bit          hit;
		r.st = STS_NOT_FOUND;
		r.vout = '0;
		r.sparse = 1'b0;
		if (k == 0) begin
			r.st = STS_NOT_FOUND;
		end else if ((op == CMD_INSERT || op == CMD_UPDATE) && v == 0) begin
			r.st = STS_NO_SLOT;
		end else if (op == CMD_INSERT) begin
			if (live_count >= fill_limit()) begin
				r.st = STS_FULL;
			end else if (!probe_slot(k, h, at)) begin
				r.st = STS_NO_SLOT;
			end else if (slot_val[at] != 0) begin
				r.st = STS_PRESENT;
				r.vout = slot_val[at];
			end else begin
				// empty slot or the key's own tombstone
				live_count++;
				slot_key[at] = k;
				slot_val[at] = v;
				r.st = STS_DONE;
			end
		end else begin
			hit = probe_slot(k, h, at);
			if (hit && slot_key[at] == k && slot_val[at] != 0) begin
				r.st = STS_DONE;
				r.vout = slot_val[at];
				if (op == CMD_UPDATE) begin
					slot_val[at] = v;
				end else if (op == CMD_REMOVE) begin
					if (live_count > 0)
						live_count--;
					slot_val[at] = '0;   // key stays as a tombstone
					if (tbl_slots > 0 &&
							live_count <= ((tbl_slots + (tbl_slots >> 1) + 2) >> 2))
						r.sparse = 1'b1;
				end
			end
		end
		r.cnt = live_count[10:0];
		r.full = live_count >= fill_limit();
		return r;
	endfunction

	// ------------------------------------------------------------------ checker

	always @(posedge clk) begin
		reply_t e;
		if (done === 1'b1) begin
			if (table_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected reply status=%0d value=%h count=%0d",
						$realtime, status, value_out, entry_count_out);
			end else begin
				e = table_replies.pop_front();
				if (status !== e.st || value_out !== e.vout ||
						entry_count_out !== e.cnt || full_flag !== e.full ||
						sparse_flag !== e.sparse) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: reply mismatch exp sts=%0d val=%h cnt=%0d ",
							"full=%0d sparse=%0d / got sts=%0d val=%h cnt=%0d ",
							"full=%0d sparse=%0d"}, $realtime,
							e.st, e.vout, e.cnt, e.full, e.sparse,
							status, value_out, entry_count_out, full_flag, sparse_flag);
				end
			end
		end
	end

	// ------------------------------------------------------------------- driver

	// present one item after the idle gap given by gap; returns at the accepting edge
	task automatic run_item(input cmd_t op, input logic [31:0] k, input logic [31:0] h,
			input logic [31:0] v, input int unsigned gap, input bit typed,
			input reply_t want);
		reply_t r;
		@(negedge clk);
		if (gap != 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd = op;
		key = k;
		key_hash = h;
		value = v;
		start = 1'b1;
		forever begin
			@(posedge clk);
			if (busy === 1'b0)
				break;
		end
		// shadow always moves; a typed row only overrides what is expected
		r = table_apply(op, k, h, v);
		table_replies.push_back(typed ? want : r);
	endtask

	// stop sending and wait for every owed reply
	task automatic drain_replies();
		@(negedge clk);
		start = 1'b0;
		while (table_replies.size() != 0)
			@(negedge clk);
	endtask

	// new size: only with the block idle, then sit out its clearing pass
	task automatic write_size(input logic [3:0] code);
		int unsigned i;
		drain_replies();
		while (busy !== 1'b0)
			@(negedge clk);
		cfg_wdata = code;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		tbl_slots = slots_for(code);
		for (i = 0; i < SLOTS; i++) begin
			slot_key[i] = '0;
			slot_val[i] = '0;
		end
		live_count = 0;
		while (busy !== 1'b1)
			@(negedge clk);
		while (busy !== 1'b0)
			@(negedge clk);
	endtask

	// ----------------------------------------------------------- directed table

	function automatic void row_size(input logic [3:0] code);
		row_t r;
		r = '{op: CMD_INSERT, want: '{st: STS_DONE, default: '0}, default: '0};
		r.is_size = 1'b1;
		r.code = code;
		directed_rows.push_back(r);
	endfunction

	function automatic void row_item(input cmd_t op, input logic [31:0] k,
			input logic [31:0] h, input logic [31:0] v);
		row_t r;
		r = '{op: CMD_INSERT, want: '{st: STS_DONE, default: '0}, default: '0};
		r.op = op;
		r.k = k;
		r.h = h;
		r.v = v;
		directed_rows.push_back(r);
	endfunction

	function automatic void row_typed(input cmd_t op, input logic [31:0] k,
			input logic [31:0] h, input logic [31:0] v, input status_t st,
			input logic [31:0] vout, input logic [10:0] cnt, input logic full,
			input logic sparse);
		row_t r;
		r = '{op: CMD_INSERT, want: '{st: STS_DONE, default: '0}, default: '0};
		r.op = op;
		r.k = k;
		r.h = h;
		r.v = v;
		r.typed = 1'b1;
		r.want.st = st;
		r.want.vout = vout;
		r.want.cnt = cnt;
		r.want.full = full;
		r.want.sparse = sparse;
		directed_rows.push_back(r);
	endfunction

	function automatic void build_directed();
		// reset size: 1024 slots
		row_typed(CMD_LOOKUP, 32'd1, 32'd0, 32'd0, STS_NOT_FOUND, 32'd0, 11'd0, 1'b0, 1'b0);
		// zero key, then zero value on insert and update
		row_typed(CMD_INSERT, 32'd0, 32'd0, 32'd5, STS_NOT_FOUND, 32'd0, 11'd0, 1'b0, 1'b0);
		row_typed(CMD_INSERT, 32'd5, 32'd5, 32'd0, STS_NO_SLOT, 32'd0, 11'd0, 1'b0, 1'b0);
		row_typed(CMD_UPDATE, 32'd5, 32'd5, 32'd0, STS_NO_SLOT, 32'd0, 11'd0, 1'b0, 1'b0);
		// all-ones key, hash and value through every command
		row_typed(CMD_INSERT, '1, '1, '1, STS_DONE, 32'd0, 11'd1, 1'b0, 1'b0);
		row_typed(CMD_INSERT, '1, '1, 32'd1, STS_PRESENT, '1, 11'd1, 1'b0, 1'b0);
		row_typed(CMD_LOOKUP, '1, '1, 32'd0, STS_DONE, '1, 11'd1, 1'b0, 1'b0);
		row_typed(CMD_UPDATE, '1, '1, 32'd1, STS_DONE, '1, 11'd1, 1'b0, 1'b0);
		row_typed(CMD_REMOVE, '1, '1, 32'd0, STS_DONE, 32'd1, 11'd0, 1'b0, 1'b1);
		row_typed(CMD_REMOVE, '1, '1, 32'd0, STS_NOT_FOUND, 32'd0, 11'd0, 1'b0, 1'b0);
		// other key steps past the tombstone; own key lands on it again
		row_item(CMD_INSERT, 32'd1, '1, 32'd2);
		row_item(CMD_INSERT, '1, '1, 32'd3);
		row_item(CMD_LOOKUP, 32'd1, '1, 32'd0);
		// zero-size table: insert is always full
		row_size(4'd0);
		row_typed(CMD_INSERT, 32'd1, 32'd0, 32'd1, STS_FULL, 32'd0, 11'd0, 1'b1, 1'b0);
		row_typed(CMD_LOOKUP, 32'd1, 32'd0, 32'd0, STS_NOT_FOUND, 32'd0, 11'd0, 1'b1, 1'b0);
		row_typed(CMD_UPDATE, 32'd1, 32'd0, 32'd1, STS_NOT_FOUND, 32'd0, 11'd0, 1'b1, 1'b0);
		row_typed(CMD_REMOVE, 32'd1, 32'd0, 32'd0, STS_NOT_FOUND, 32'd0, 11'd0, 1'b1, 1'b0);
		// two slots: collide, fill, then a tombstone blocks the probe
		row_size(4'd2);
		row_typed(CMD_INSERT, 32'd7, 32'd0, 32'd10, STS_DONE, 32'd0, 11'd1, 1'b0, 1'b0);
		row_item(CMD_INSERT, 32'd9, 32'd0, 32'd20);
		row_typed(CMD_INSERT, 32'd11, 32'd0, 32'd30, STS_FULL, 32'd0, 11'd2, 1'b1, 1'b0);
		row_item(CMD_REMOVE, 32'd7, 32'd0, 32'd0);
		row_item(CMD_INSERT, 32'd11, 32'd0, 32'd30);
		// one slot
		row_size(4'd1);
		row_item(CMD_INSERT, 32'd3, 32'd123, 32'd3);
		row_item(CMD_LOOKUP, 32'd3, 32'd0, 32'd0);
		// out-of-range code behaves as the largest size
		row_size(4'd15);
		row_item(CMD_INSERT, 32'h8000_0000, 32'h1234_5678, 32'h55AA_55AA);
		row_item(CMD_LOOKUP, 32'h8000_0000, 32'hFFFF_0000, 32'd0);
	endfunction

	// ------------------------------------------------------------------ sequence

	initial begin
		logic [3:0]  phase_code [14];
		int unsigned phase_len  [14];
		logic [31:0] pool_key [160];
		logic [31:0] pool_hash [160];
		int unsigned pool_n;
		int unsigned p;
		int unsigned n;
		int unsigned pick;
		int unsigned roll;
		bit          idle_on;
		cmd_t        op;
		logic [31:0] k;
		logic [31:0] h;
		logic [31:0] v;
		reply_t      none;

		phase_code = '{4'd3, 4'd1, 4'd4, 4'd2, 4'd5, 4'd0, 4'd6, 4'd12,
			4'd3, 4'd8, 4'd15, 4'd4, 4'd11, 4'd7};
		phase_len = '{120, 60, 150, 80, 150, 40, 150, 120, 120, 250, 80, 150, 100, 130};
		none = '{st: STS_DONE, default: '0};

		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_INSERT;
		key = '0;
		key_hash = '0;
		value = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		mismatches = 0;
		live_count = 0;
		tbl_slots = slots_for(CODE_MAX);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// clearing pass after reset
		@(negedge clk);
		while (busy !== 1'b0)
			@(negedge clk);

		build_directed();
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_size)
				write_size(directed_rows[i].code);
			else
				run_item(directed_rows[i].op, directed_rows[i].k, directed_rows[i].h,
					directed_rows[i].v, $urandom_range(0, 9), directed_rows[i].typed,
					directed_rows[i].want);
		end

		// random phases: a key pool sized to the table, at most 160 keys, so keys recur,
		// collide and fill the smaller tables; half the pool hashes land in a narrow range
		for (p = 0; p < 14; p++) begin
			write_size(phase_code[p]);
			pool_n = 2 * slots_for(phase_code[p]) + 4;
			if (pool_n > 160)
				pool_n = 160;
			for (n = 0; n < pool_n; n++) begin
				pool_key[n] = $urandom;
				if (pool_key[n] == 0)
					pool_key[n] = 32'd1;
				pool_hash[n] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 7);
			end
			idle_on = 1'b1;
			for (n = 0; n < phase_len[p]; n++) begin
				if (n % 32 == 0)
					idle_on = $urandom_range(0, 2) != 0;
				// sender holds off until the block has answered everything
				if (n == phase_len[p] / 2)
					drain_replies();
				roll = $urandom_range(0, 99);
				if (roll < 40)
					op = CMD_INSERT;
				else if (roll < 65)
					op = CMD_LOOKUP;
				else if (roll < 80)
					op = CMD_UPDATE;
				else
					op = CMD_REMOVE;
				pick = $urandom_range(0, pool_n - 1);
				k = pool_key[pick];
				h = pool_hash[pick];
				roll = $urandom_range(0, 99);
				if (roll < 3)
					k = '0;
				else if (roll < 8)
					k = $urandom;
				if ($urandom_range(0, 99) < 12)
					h = $urandom;
				v = $urandom;
				roll = $urandom_range(0, 99);
				if (roll < 3)
					v = '0;
				else if (roll < 6 || v == 0)
					v = '1;
				run_item(op, k, h, v, idle_on ? $urandom_range(0, 9) : 0, 1'b0, none);
			end
		end

		drain_replies();
		// longest probe is one pass over the largest table
		repeat (SLOTS + 64) @(posedge clk);
		if (mismatches == 0 && table_replies.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
